// File: rtl/ntfl_pkg.sv
package ntfl_pkg;

  localparam int TableDepth = 64;
  localparam int MaxNameLen = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [4:0] MAX_DIST_RESET = 5'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic       last_char;
    logic [3:0] arity;
    logic       derived;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] match_index;
    logic [3:0] match_arity;
    logic       match_derived;
    logic       suggest_valid;
    logic [5:0] suggest_index;
    logic [4:0] suggest_distance;
  } out_word_t;

endpackage

// File: rtl/ntfl_dist_row.sv
// Full Levenshtein DP distance per start: rows i of the name vs. entry chars.
// Processes columns one per cycle; a row is MaxLen+1 cells of DW bits each.
module ntfl_dist_row #(
  parameter int MAX_NAME_LEN = ntfl_pkg::MaxNameLen,
  parameter int LW = $clog2(MAX_NAME_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] len_a,
  input  logic [LW-1:0] len_b,
  input  logic [MAX_NAME_LEN-1:0][7:0] name_a,
  input  logic [MAX_NAME_LEN-1:0][7:0] name_b,
  output logic          done,
  output logic [LW:0]   distance
);
  localparam int DW = LW + 1;
  logic [MAX_NAME_LEN:0][DW-1:0] prev, cur;
  logic [MAX_NAME_LEN:0][DW-1:0] row_next;
  logic [LW-1:0] i, j;
  logic busy;
  logic [DW-1:0] up, left, diag, m1, cand;
  logic [LW-1:0] jm1, im1;

  always_comb begin
    jm1  = j - LW'(1);
    im1  = i - LW'(1);
    up   = prev[j] + DW'(1);
    left = cur[jm1] + DW'(1);
    diag = prev[jm1] + ((name_a[im1[$clog2(MAX_NAME_LEN)-1:0]] ==
                         name_b[jm1[$clog2(MAX_NAME_LEN)-1:0]]) ? DW'(0) : DW'(1));
    m1   = (up < left) ? up : left;
    cand = (m1 < diag) ? m1 : diag;
    // finished row, including the column computed this cycle
    row_next = cur;
    row_next[j] = cand;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      for (int k = 0; k <= MAX_NAME_LEN; k++) prev[k] <= DW'(k);
      i <= LW'(1);
      j <= LW'(1);
      cur[0] <= DW'(1);
      if (len_a == '0 || len_b == '0) begin
        distance <= (len_a == '0) ? DW'(len_b) : DW'(len_a);
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
      end
    end else if (busy) begin
      cur[j] <= cand;
      if (j == len_b) begin
        if (i == len_a) begin
          busy <= 1'b0;
          done <= 1'b1;
          distance <= cand;
        end else begin
          prev <= row_next;
          cur[0] <= DW'(i) + DW'(1);
          i <= i + LW'(1);
          j <= LW'(1);
        end
      end else begin
        j <= j + LW'(1);
      end
    end
  end

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> distance <= DW'(MAX_NAME_LEN)) else $error("distance out of range");
  a_busy_no_start: assert property (@(posedge clk) disable iff (rst)
    busy |=> !done || $past(busy)) else $error("done without pass");
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> j <= len_b && i <= len_a) else $error("index overrun");
endmodule

// File: rtl/name_table_fuzzy_lookup.sv
// Flow: unless too long or the table is empty, a name end reads and compares each
//   entry; queries add a distance pass per entry, new inserts write the name, and
//   the result goes into the output register.
// Throughput: one word at a time; ready is low during a name end and while its
//   result waits behind an unaccepted one. Char memory reads set the scan rate.
// Reset: synchronous rst clears count, name buffer state, FSM and config (3).
module name_table_fuzzy_lookup #(
  parameter int TABLE_DEPTH  = ntfl_pkg::TableDepth,
  parameter int MAX_NAME_LEN = ntfl_pkg::MaxNameLen
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ntfl_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ntfl_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_NAME_LEN + 1);
  localparam int PW = $clog2(MAX_NAME_LEN);
  localparam int AW = IW + PW;

  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CMP = 3'd2,
                         S_DIST = 3'd3, S_WRITE = 3'd4, S_OUT = 3'd5;

  logic [2:0] state;
  logic [4:0] max_dist;
  logic [CW-1:0] count;
  logic [MAX_NAME_LEN-1:0][7:0] nbuf, ebuf;
  logic [LW-1:0] nlen;
  logic ovf;
  logic [1:0] end_op;
  logic [3:0] end_arity;
  logic end_derived;

  logic [7:0] chars_mem [2**AW];
  logic [LW-1:0] len_mem [TABLE_DEPTH];
  logic [4:0] attr_mem [TABLE_DEPTH];
  logic [7:0] rd_char;
  logic [LW-1:0] rd_len;
  logic [4:0] rd_attr;

  logic [IW-1:0] ent;
  logic [LW-1:0] pos;
  logic rd_pend;
  logic [PW-1:0] rd_pos;
  logic [LW-1:0] wpos;
  logic found;
  logic [4:0] fattr;
  logic have;
  logic [LW:0] bdist;
  logic dstart, ddone;
  logic [LW:0] dres;
  logic [LW-1:0] elen;
  logic [AW-1:0] raddr;
  logic last_ent;

  ntfl_pkg::out_word_t res;

  assign in_ready = (state == S_IDLE);
  assign raddr = {ent, pos[PW-1:0]};
  assign last_ent = (CW'(ent) + CW'(1) >= count);

  always_ff @(posedge clk) begin
    rd_char <= chars_mem[raddr];
    rd_len  <= len_mem[ent];
    rd_attr <= attr_mem[ent];
    if (state == S_WRITE && wpos < nlen)
      chars_mem[{IW'(count), wpos[PW-1:0]}] <= nbuf[wpos[PW-1:0]];
    if (state == S_WRITE && wpos == nlen) begin
      len_mem[IW'(count)]  <= nlen;
      attr_mem[IW'(count)] <= {end_arity, end_derived};
    end
  end

  ntfl_dist_row #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_dist (
    .clk, .rst, .start(dstart), .len_a(nlen), .len_b(elen),
    .name_a(nbuf), .name_b(ebuf), .done(ddone), .distance(dres)
  );

  function automatic logic names_eq(input logic [MAX_NAME_LEN-1:0][7:0] a,
                                    input logic [MAX_NAME_LEN-1:0][7:0] b,
                                    input logic [LW-1:0] n);
    logic eq;
    eq = 1'b1;
    for (int k = 0; k < MAX_NAME_LEN; k++)
      if (LW'(k) < n && a[k] != b[k]) eq = 1'b0;
    return eq;
  endfunction

  logic ent_eq;
  assign ent_eq = (elen == nlen) && names_eq(nbuf, ebuf, nlen);

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE; max_dist <= ntfl_pkg::MAX_DIST_RESET; count <= '0;
      nlen <= '0; ovf <= 1'b0; out_valid <= 1'b0; rd_pend <= 1'b0;
    end else begin
      if (cfg_we) max_dist <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.op == ntfl_pkg::OP_CLEAR) begin
              count <= '0; nlen <= '0; ovf <= 1'b0;
            end else if (in_data.op == ntfl_pkg::OP_INSERT ||
                         in_data.op == ntfl_pkg::OP_QUERY) begin
              if (nlen < LW'(MAX_NAME_LEN)) begin
                nbuf[nlen[PW-1:0]] <= in_data.char_code;
                nlen <= nlen + LW'(1);
              end else begin
                ovf <= 1'b1;
              end
              if (in_data.last_char) begin
                end_op <= in_data.op; end_arity <= in_data.arity;
                end_derived <= in_data.derived;
                found <= 1'b0; have <= 1'b0;
                ent <= '0; pos <= '0; wpos <= '0;
                if (ovf || nlen == LW'(MAX_NAME_LEN)) begin
                  res <= '{status: ntfl_pkg::ST_TOO_LONG, default: '0};
                  state <= S_OUT;
                end else if (count == '0) begin
                  res <= '0;
                  state <= (in_data.op == ntfl_pkg::OP_INSERT) ? S_WRITE : S_OUT;
                end else begin
                  res <= '0;
                  state <= S_READ; rd_pend <= 1'b0;
                end
              end
            end
          end
        end
        // stream chars of entry ent into ebuf, one per cycle
        S_READ: begin
          rd_pend <= (pos != LW'(MAX_NAME_LEN));
          rd_pos <= pos[PW-1:0];
          if (rd_pend) ebuf[rd_pos] <= rd_char;
          if (pos == LW'(MAX_NAME_LEN)) begin
            state <= S_CMP; elen <= rd_len; fattr <= rd_attr;
          end else begin
            pos <= pos + LW'(1);
          end
        end
        S_CMP: begin
          if (!found && ent_eq) begin
            found <= 1'b1;
          end
          if (end_op == ntfl_pkg::OP_QUERY) begin
            dstart <= 1'b1; state <= S_DIST;
          end else if (ent_eq) begin
            res.status <= ntfl_pkg::ST_DUPLICATE;
            res.match_index <= 6'(ent); res.match_arity <= fattr[4:1];
            res.match_derived <= fattr[0]; state <= S_OUT;
          end else if (last_ent) begin
            if (count >= CW'(TABLE_DEPTH)) begin
              res.status <= ntfl_pkg::ST_FULL; state <= S_OUT;
            end else state <= S_WRITE;
          end else begin
            ent <= ent + IW'(1); pos <= '0; state <= S_READ;
          end
          if (!found && ent_eq && end_op == ntfl_pkg::OP_QUERY) begin
            res.found <= 1'b1; res.match_index <= 6'(ent);
            res.match_arity <= fattr[4:1]; res.match_derived <= fattr[0];
          end
        end
        S_DIST: begin
          if (ddone) begin
            if ({1'b0, dres} <= (LW+2)'(max_dist) && (!have || dres < bdist)) begin
              have <= 1'b1; bdist <= dres;
              res.suggest_valid <= 1'b1; res.suggest_index <= 6'(ent);
              res.suggest_distance <= 5'(dres);
            end
            if (last_ent) state <= S_OUT;
            else begin
              ent <= ent + IW'(1); pos <= '0; state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          wpos <= wpos + LW'(1);
          if (wpos == nlen) begin
            res.status <= ntfl_pkg::ST_OK;
            res.match_index <= 6'(count); res.match_arity <= end_arity;
            res.match_derived <= end_derived;
            count <= count + CW'(1); state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1; out_data <= res;
            nlen <= '0; ovf <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == ntfl_pkg::ST_OK)
    else $error("found with bad status");
  a_sugg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.suggest_valid |-> out_data.suggest_distance <= max_dist)
    else $error("suggestion beyond limit");
endmodule

// File: verif/name_table_fuzzy_lookup_tb.sv
`timescale 1ns / 1ps

module name_table_fuzzy_lookup_tb;

  localparam int Depth = ntfl_pkg::TableDepth;
  localparam int NameMax = ntfl_pkg::MaxNameLen;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CycleLimit = 20000000;
  localparam int SettleCycles = 40000;
  localparam int HoldCycles = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  ntfl_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  ntfl_pkg::out_word_t out_data;
  logic cfg_we;
  logic [4:0] cfg_data;

  name_table_fuzzy_lookup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the table
  logic [7:0] tbl_chars [Depth][NameMax];
  int tbl_len [Depth];
  logic [3:0] tbl_arity [Depth];
  logic tbl_derived [Depth];
  int tbl_count;
  logic [7:0] pend_chars [NameMax];
  int pend_len;
  bit pend_overflow;
  int dist_limit;

  ntfl_pkg::out_word_t lookup_q[$];
  int errors;
  int results_seen;
  int words_sent;
  int cycles;
  bit hold_off;
  bit end_settle;
  int rx_wait;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("name_table_fuzzy_lookup_tb: done, errors");
      $finish;
    end
  end

  function automatic int lev_distance(int e);
    int prev [NameMax+1];
    int cur [NameMax+1];
    int lb;
    int m;
    lb = tbl_len[e];
    for (int j = 0; j <= lb; j++) prev[j] = j;
    for (int i = 1; i <= pend_len; i++) begin
      cur[0] = i;
      for (int j = 1; j <= lb; j++) begin
        m = prev[j] + 1;
        if (cur[j-1] + 1 < m) m = cur[j-1] + 1;
        if (prev[j-1] + (pend_chars[i-1] == tbl_chars[e][j-1] ? 0 : 1) < m)
          m = prev[j-1] + (pend_chars[i-1] == tbl_chars[e][j-1] ? 0 : 1);
        cur[j] = m;
      end
      prev = cur;
    end
    return prev[lb];
  endfunction

  function automatic int exact_index();
    bit same;
    for (int e = 0; e < tbl_count; e++) begin
      if (tbl_len[e] == pend_len) begin
        same = 1;
        for (int k = 0; k < pend_len; k++)
          if (tbl_chars[e][k] != pend_chars[k]) same = 0;
        if (same) return e;
      end
    end
    return -1;
  endfunction

  // advance the shadow by one accepted word; queue any result it causes
  function automatic void predict_lookup(ntfl_pkg::in_word_t w);
    ntfl_pkg::out_word_t r;
    int idx;
    int d;
    bit have;
    int best_d;
    if (w.op == ntfl_pkg::OP_CLEAR) begin
      tbl_count = 0; pend_len = 0; pend_overflow = 0;
      return;
    end
    if (w.op != ntfl_pkg::OP_INSERT && w.op != ntfl_pkg::OP_QUERY) return;
    if (pend_len < NameMax) begin
      pend_chars[pend_len] = w.char_code;
      pend_len++;
    end else pend_overflow = 1;
    if (!w.last_char) return;
    r = '0;
    if (pend_overflow) r.status = ntfl_pkg::ST_TOO_LONG;
    else if (w.op == ntfl_pkg::OP_INSERT) begin
      idx = exact_index();
      if (idx >= 0) begin
        r.status = ntfl_pkg::ST_DUPLICATE;
        r.match_index = idx[5:0];
        r.match_arity = tbl_arity[idx];
        r.match_derived = tbl_derived[idx];
      end else if (tbl_count >= Depth) r.status = ntfl_pkg::ST_FULL;
      else begin
        idx = tbl_count;
        for (int k = 0; k < pend_len; k++) tbl_chars[idx][k] = pend_chars[k];
        tbl_len[idx] = pend_len;
        tbl_arity[idx] = w.arity;
        tbl_derived[idx] = w.derived;
        tbl_count++;
        r.status = ntfl_pkg::ST_OK;
        r.match_index = idx[5:0];
        r.match_arity = w.arity;
        r.match_derived = w.derived;
      end
    end else begin
      idx = exact_index();
      if (idx >= 0) begin
        r.found = 1;
        r.match_index = idx[5:0];
        r.match_arity = tbl_arity[idx];
        r.match_derived = tbl_derived[idx];
      end
      have = 0; best_d = 0;
      for (int e = 0; e < tbl_count; e++) begin
        d = lev_distance(e);
        if (d <= dist_limit && (!have || d < best_d)) begin
          have = 1; best_d = d;
          r.suggest_index = e[5:0];
        end
      end
      if (have) begin
        r.suggest_valid = 1;
        r.suggest_distance = best_d[4:0];
      end
    end
    pend_len = 0;
    pend_overflow = 0;
    lookup_q.push_back(r);
  endfunction

  // receiver: counts down a random rx_wait per result before ready, or holds off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= $urandom_range(0, 16);
    end else if (hold_off) out_ready <= 1'b0;
    else if (out_valid && out_ready) begin
      out_ready <= 1'b0;
      rx_wait <= end_settle ? 0 : $urandom_range(0, 16);
    end else if (out_valid && rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else out_ready <= (rx_wait == 0);
  end

  // result checker
  always @(posedge clk) begin
    ntfl_pkg::out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        errors <= errors + 1;
      end else begin
        exp_w = lookup_q.pop_front();
        if (out_data !== exp_w) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_w, out_data);
          if (out_data.status !== exp_w.status)
            $display("  status exp %0d got %0d", exp_w.status, out_data.status);
          if (out_data.match_index !== exp_w.match_index)
            $display("  match_index exp %0d got %0d", exp_w.match_index,
                     out_data.match_index);
          if (out_data.suggest_index !== exp_w.suggest_index ||
              out_data.suggest_distance !== exp_w.suggest_distance)
            $display("  suggest exp %0d/%0d got %0d/%0d", exp_w.suggest_index,
                     exp_w.suggest_distance, out_data.suggest_index,
                     out_data.suggest_distance);
          errors <= errors + 1;
        end
      end
    end
  end

  // valid stays high across back-to-back words; it drops only for a gap
  task automatic send_word(ntfl_pkg::in_word_t w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_lookup(w);
    words_sent++;
  endtask

  task automatic send_name(logic [1:0] op, logic [7:0] s [$], logic [3:0] ar = 0,
                           bit dv = 0);
    ntfl_pkg::in_word_t w;
    for (int k = 0; k < s.size(); k++) begin
      w.op = op;
      w.char_code = s[k];
      w.last_char = (k == s.size() - 1);
      w.arity = ar;
      w.derived = dv;
      send_word(w);
    end
  endtask

  task automatic send_clear();
    ntfl_pkg::in_word_t w;
    w = '0;
    w.op = ntfl_pkg::OP_CLEAR;
    w.char_code = 8'($urandom);
    send_word(w);
  endtask

  task automatic drain();
    int extra;
    extra = 0;
    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    while (extra < 2000) begin
      @(posedge clk);
      extra++;
    end
  endtask

  task automatic write_limit(logic [4:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    dist_limit = v;
  endtask

  // short name over a small alphabet so distances stay interesting
  function automatic void rand_name(ref logic [7:0] s [$], input int maxlen);
    int n;
    s.delete();
    n = $urandom_range(1, maxlen);
    for (int k = 0; k < n; k++)
      s.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(97, 100)));
  endfunction

  task automatic test_directed();
    logic [7:0] s [$];
    ntfl_pkg::in_word_t w;
    s = {8'h61, 8'h62, 8'h63};
    send_name(ntfl_pkg::OP_INSERT, s, 4'hF, 1);
    send_name(ntfl_pkg::OP_INSERT, s, 4'h2, 0);   // duplicate
    send_name(ntfl_pkg::OP_QUERY, s);             // exact hit
    s = {8'h00, 8'hFF};
    send_name(ntfl_pkg::OP_INSERT, s, 4'h0, 0);   // zero and max char codes
    s = {8'h61, 8'h62, 8'h64};
    send_name(ntfl_pkg::OP_QUERY, s);             // near miss
    // first chars say insert, last says query
    w = '{op: ntfl_pkg::OP_INSERT, char_code: 8'h61, last_char: 0, arity: 4'h5,
          derived: 1};
    send_word(w);
    w = '{op: ntfl_pkg::OP_QUERY, char_code: 8'h62, last_char: 1, arity: 4'hA,
          derived: 0};
    send_word(w);
    s.delete();
    for (int k = 0; k < NameMax; k++) s.push_back(8'(8'h41 + k));
    send_name(ntfl_pkg::OP_INSERT, s, 4'h3, 1);   // exactly max length
    s.push_back(8'h7A);
    send_name(ntfl_pkg::OP_QUERY, s);             // too long
    w = '{op: OP_UNUSED, char_code: 8'h55, last_char: 1, arity: 4'hF, derived: 1};
    send_word(w);                                 // ignored op
    w = '{op: ntfl_pkg::OP_INSERT, char_code: 8'h55, last_char: 0, arity: 0,
          derived: 0};
    send_word(w);
    send_clear();                                 // drops partial name
    s = {8'h61};
    send_name(ntfl_pkg::OP_QUERY, s);             // empty table
  endtask

  task automatic test_full_table();
    logic [7:0] s [$];
    send_clear();
    for (int e = 0; e <= Depth; e++) begin
      s = {8'(8'h30 + e), 8'(8'h80 + e)};
      send_name(ntfl_pkg::OP_INSERT, s, 4'(e), e[0]);
    end
    s = {8'h30, 8'h80};
    send_name(ntfl_pkg::OP_QUERY, s);
    send_clear();
  endtask

  task automatic test_random(int n_words);
    logic [7:0] s [$];
    int start;
    int r;
    start = words_sent;
    while (words_sent - start < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_clear();
      else if (r < 8) begin
        ntfl_pkg::in_word_t w;
        w = ntfl_pkg::in_word_t'(16'($urandom));
        send_word(w);
      end else if (r < 12) begin
        rand_name(s, NameMax);
        for (int k = 0; k < 3; k++) s.push_back(8'($urandom));
        send_name(r[0] ? ntfl_pkg::OP_INSERT : ntfl_pkg::OP_QUERY, s);
      end else begin
        rand_name(s, (r < 80) ? 5 : NameMax);
        send_name(r < 50 ? ntfl_pkg::OP_INSERT : ntfl_pkg::OP_QUERY, s, 4'($urandom),
                  1'($urandom_range(0, 1)));
      end
      if (tbl_count > 40 && $urandom_range(0, 5) == 0) send_clear();
    end
  endtask

  // receiver holds off while the sender keeps pushing names
  task automatic test_backpressure();
    logic [7:0] s [$];
    hold_off = 1;
    fork
      begin
        int n;
        n = 0;
        while (n < HoldCycles) begin
          @(posedge clk);
          n++;
        end
        hold_off = 0;
      end
      for (int k = 0; k < 20; k++) begin
        rand_name(s, 4);
        send_name(ntfl_pkg::OP_QUERY, s);
      end
    join
  endtask

  initial begin
    errors = 0; results_seen = 0; words_sent = 0; cycles = 0;
    hold_off = 0; end_settle = 0;
    tbl_count = 0; pend_len = 0; pend_overflow = 0;
    dist_limit = ntfl_pkg::MAX_DIST_RESET;
    rst = 1; in_valid = 0; in_data = '0; cfg_we = 0; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    test_directed();
    test_full_table();
    test_random(250);
    test_backpressure();
    write_limit(5'd0);
    test_random(200);
    write_limit(5'd16);
    test_random(200);
    write_limit(5'd1);
    test_random(150);
    in_valid <= 1'b0;
    end_settle = 1;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d words, %0d name results, limits 3/0/16/1, full table, stall",
             words_sent, results_seen);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("name_table_fuzzy_lookup_tb: done, clean");
    end else begin
      $display("name_table_fuzzy_lookup_tb: done, errors");
    end
    $finish;
  end

endmodule
